### src/bqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqs_pkg: shared types and codes of the biquadratic root solver
// Holds the pipeline flow control group and the root count codes.
// ----------------------------------------------------------------------------
package bqs_pkg;

    // Width of the root count field.
    localparam int ROOT_COUNT_W = 3;

    // Root count codes.
    localparam logic [ROOT_COUNT_W-1:0] ROOTS_NONE = 3'd0;
    localparam logic [ROOT_COUNT_W-1:0] ROOTS_PAIR = 3'd2;
    localparam logic [ROOT_COUNT_W-1:0] ROOTS_QUAD = 3'd4;

    // Flow control handed to every pipelined unit.
    typedef struct packed {
        logic valid;    // an item enters the unit
        logic advance;  // the whole pipeline moves one stage
    } t_flow;

endpackage

### src/bqs_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqs_isqrt: pipelined integer square root
// Digit-by-digit square root, one root bit per register stage, with a
// sideband word and a valid bit that travel alongside each item.
// ----------------------------------------------------------------------------
module bqs_isqrt #(
    parameter int IN_W = 66,
    parameter int SB_W = 1,
    localparam int N   = (IN_W + 1) / 2,
    localparam int XW  = 2 * N
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bqs_pkg::t_flow      i_flow,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [N-1:0]        o_root,
    output logic [SB_W-1:0]     o_sb
);

    logic [XW-1:0]   r_x   [N];
    logic [XW-1:0]   r_res [N];
    logic [SB_W-1:0] r_sb  [N];
    logic [N-1:0]    r_valid;

    logic [XW-1:0]   n_x   [N];
    logic [XW-1:0]   n_res [N];
    logic [SB_W-1:0] n_sb  [N];
    logic [N-1:0]    n_valid;

    // Each stage tries one root bit and keeps the remainder.
    always_comb begin
        logic [XW-1:0] px;
        logic [XW-1:0] pr;
        logic [XW-1:0] bitk;
        logic [XW-1:0] trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                px         = XW'(i_rad);
                pr         = '0;
                n_sb[k]    = i_sb;
                n_valid[k] = i_flow.valid;
            end else begin
                px         = r_x[k-1];
                pr         = r_res[k-1];
                n_sb[k]    = r_sb[k-1];
                n_valid[k] = r_valid[k-1];
            end
            bitk  = {{(XW-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
            trial = pr + bitk;
            if (px >= trial) begin
                n_x[k]   = px - trial;
                n_res[k] = (pr >> 1) + bitk;
            end else begin
                n_x[k]   = px;
                n_res[k] = pr >> 1;
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_flow.advance) begin
            r_valid <= n_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_flow.advance) begin
            for (int k = 0; k < N; k++) begin
                r_x[k]   <= n_x[k];
                r_res[k] <= n_res[k];
                r_sb[k]  <= n_sb[k];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = r_res[N-1][N-1:0];
    assign o_sb    = r_sb[N-1];

endmodule

### src/bqs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqs_div: pipelined fixed-point divider
// Restoring long division of (num << FRAC_SHIFT) by den, one quotient bit per
// register stage, with a sideband word and a valid bit beside each item.
// ----------------------------------------------------------------------------
module bqs_div #(
    parameter int NUM_W      = 33,
    parameter int DEN_W      = 33,
    parameter int FRAC_SHIFT = 32,
    parameter int SB_W       = 1,
    localparam int QW        = NUM_W + FRAC_SHIFT,
    localparam int RW        = DEN_W + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bqs_pkg::t_flow      i_flow,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [QW-1:0]       o_quo,
    output logic [SB_W-1:0]     o_sb
);

    // The dividend shifts out at the top while quotient bits shift in below.
    logic [QW-1:0]    r_qd  [QW];
    logic [RW-1:0]    r_rem [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [SB_W-1:0]  r_sb  [QW];
    logic [QW-1:0]    r_valid;

    logic [QW-1:0]    n_qd  [QW];
    logic [RW-1:0]    n_rem [QW];
    logic [DEN_W-1:0] n_den [QW];
    logic [SB_W-1:0]  n_sb  [QW];
    logic [QW-1:0]    n_valid;

    // One shift, compare and subtract per stage.
    always_comb begin
        logic [QW-1:0]    pqd;
        logic [RW-1:0]    prem;
        logic [RW-1:0]    sh;
        logic [RW-1:0]    dext;
        logic             fit;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                pqd        = {i_num, {FRAC_SHIFT{1'b0}}};
                prem       = '0;
                n_den[k]   = i_den;
                n_sb[k]    = i_sb;
                n_valid[k] = i_flow.valid;
            end else begin
                pqd        = r_qd[k-1];
                prem       = r_rem[k-1];
                n_den[k]   = r_den[k-1];
                n_sb[k]    = r_sb[k-1];
                n_valid[k] = r_valid[k-1];
            end
            sh       = {prem[RW-2:0], pqd[QW-1]};
            dext     = {1'b0, n_den[k]};
            fit      = (sh >= dext);
            n_rem[k] = fit ? (sh - dext) : sh;
            n_qd[k]  = {pqd[QW-2:0], fit};
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_flow.advance) begin
            r_valid <= n_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_flow.advance) begin
            for (int k = 0; k < QW; k++) begin
                r_qd[k]  <= n_qd[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_sb[k]  <= n_sb[k];
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_qd[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

### src/biquadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquadratic_root_solver_top: real roots of a*x^4 + b*x^2 + c = 0
// Fixed-point solver built as one long pipeline: unpack, products,
// discriminant, discriminant root, numerators, two dividers, two roots, output.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)                          tuser
//  s_axis   in   coef_quartic, coef_square, coef_constant    -
//  m_axis   out  root_count, root_0, root_1, root_2, root_3  infinite_solutions
//
// One item enters per cycle while the output item is not held. The
// discriminant root, divider and root pipelines work one bit per stage.
// Reset is synchronous and clears only the valid bits.
// When the output item is held, the whole pipeline freezes in place.
// ----------------------------------------------------------------------------
module biquadratic_root_solver_top #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16,
    localparam int IN_TW  = ((3 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((bqs_pkg::ROOT_COUNT_W + 4 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // coef_quartic, coef_square, coef_constant
    input  logic [IN_TW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // root_count, root_0, root_1, root_2, root_3, zero fill
    output logic [OUT_TW-1:0] m_axis_tdata,
    // infinite_solutions
    output logic [0:0]        m_axis_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int DDW   = 2 * W + 2;           // discriminant
    localparam int SW    = (DDW + 1) / 2;       // its square root
    localparam int SNW   = W + 3;               // signed numerators
    localparam int NW    = W + 1;               // numerator magnitude
    localparam int DNW   = W + 1;               // denominator magnitude
    localparam int QW    = NW + 2 * F;          // quotient
    localparam int RTW   = (QW + 1) / 2;        // root before saturation
    localparam int CW    = (RTW > W) ? RTW : W;
    localparam int SBD_W = 6 + 3 * W;
    localparam int CNT_W = bqs_pkg::ROOT_COUNT_W;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

    logic w_adv;

    // The pipeline moves whenever the output register can take an item.
    logic r_out_valid;
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Stage 1: unpack signs and magnitudes.
    logic [W-1:0] w_a_raw, w_b_raw, w_c_raw;
    logic         r1_valid, r1_na, r1_nb, r1_nc;
    logic [W-1:0] r1_ma, r1_mb, r1_mc;

    assign w_a_raw = s_axis_tdata[W-1:0];
    assign w_b_raw = s_axis_tdata[2*W-1:W];
    assign w_c_raw = s_axis_tdata[3*W-1:2*W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_na <= w_a_raw[W-1];
            r1_nb <= w_b_raw[W-1];
            r1_nc <= w_c_raw[W-1];
            r1_ma <= w_a_raw[W-1] ? (~w_a_raw + {{(W-1){1'b0}}, 1'b1}) : w_a_raw;
            r1_mb <= w_b_raw[W-1] ? (~w_b_raw + {{(W-1){1'b0}}, 1'b1}) : w_b_raw;
            r1_mc <= w_c_raw[W-1] ? (~w_c_raw + {{(W-1){1'b0}}, 1'b1}) : w_c_raw;
        end
    end

    // Stage 2: the products b*b and a*c.
    logic           r2_valid, r2_na, r2_nb, r2_nc;
    logic [W-1:0]   r2_ma, r2_mb, r2_mc;
    logic [2*W-1:0] r2_b2, r2_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_b2 <= r1_mb * r1_mb;
            r2_ac <= r1_ma * r1_mc;
            r2_ma <= r1_ma;
            r2_mb <= r1_mb;
            r2_mc <= r1_mc;
            r2_na <= r1_na;
            r2_nb <= r1_nb;
            r2_nc <= r1_nc;
        end
    end

    // Stage 3: discriminant and the flags of the special cases.
    logic [DDW-1:0] w_b2e, w_p4;
    logic           r3_valid, r3_ok, r3_inf, r3_lin, r3_lin_v, r3_na, r3_nb;
    logic [DDW-1:0] r3_d;
    logic [W-1:0]   r3_ma, r3_mb, r3_mc;

    assign w_b2e = {2'b00, r2_b2};
    assign w_p4  = {r2_ac, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r2_na != r2_nc) begin
                r3_d  <= w_b2e + w_p4;
                r3_ok <= 1'b1;
            end else begin
                r3_d  <= w_b2e - w_p4;
                r3_ok <= (w_p4 <= w_b2e);
            end
            r3_inf   <= (r2_ma == '0) && (r2_mb == '0) && (r2_mc == '0);
            r3_lin   <= (r2_ma == '0);
            r3_lin_v <= (r2_mb != '0) && ((r2_mc == '0) || (r2_nc != r2_nb));
            r3_na    <= r2_na;
            r3_nb    <= r2_nb;
            r3_ma    <= r2_ma;
            r3_mb    <= r2_mb;
            r3_mc    <= r2_mc;
        end
    end

    // Square root of the discriminant.
    bqs_pkg::t_flow   w_flow_d;
    logic             w_sd_valid;
    logic [SW-1:0]    w_s;
    logic [SBD_W-1:0] w_sbd;

    assign w_flow_d = '{valid: r3_valid, advance: w_adv};

    bqs_isqrt #(
        .IN_W (DDW),
        .SB_W (SBD_W)
    ) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow_d),
        .i_rad   (r3_d),
        .i_sb    ({r3_inf, r3_lin, r3_lin_v, r3_ok, r3_na, r3_nb, r3_ma, r3_mb, r3_mc}),
        .o_valid (w_sd_valid),
        .o_root  (w_s),
        .o_sb    (w_sbd)
    );

    // Stage 4: numerators -b + s and -b - s, and the choice of each path.
    logic           w_inf, w_lin, w_lin_v, w_ok, w_na, w_nb;
    logic [W-1:0]   w_ma, w_mb, w_mc;
    logic [SNW-1:0] w_bext, w_negb, w_sext, w_n1, w_n2, w_n1a, w_n2a;
    logic           w_v1q, w_v2q;

    assign {w_inf, w_lin, w_lin_v, w_ok, w_na, w_nb, w_ma, w_mb, w_mc} = w_sbd;

    always_comb begin
        w_bext = {3'b000, w_mb};
        w_negb = w_nb ? w_bext : (~w_bext + {{(SNW-1){1'b0}}, 1'b1});
        w_sext = SNW'(w_s);
        w_n1   = w_negb + w_sext;
        w_n2   = w_negb - w_sext;
        w_n1a  = w_n1[SNW-1] ? (~w_n1 + {{(SNW-1){1'b0}}, 1'b1}) : w_n1;
        w_n2a  = w_n2[SNW-1] ? (~w_n2 + {{(SNW-1){1'b0}}, 1'b1}) : w_n2;
        // A root y needs a zero numerator or the sign of the denominator.
        w_v1q  = w_ok && ((w_n1 == '0) || (w_n1[SNW-1] == w_na));
        // A double root in y is taken once.
        w_v2q  = w_ok && (w_s != '0) && ((w_n2 == '0) || (w_n2[SNW-1] == w_na));
    end

    logic           r4_valid, r4_inf, r4_v1, r4_v2;
    logic [NW-1:0]  r4_num1, r4_num2;
    logic [DNW-1:0] r4_den1, r4_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r4_valid <= w_sd_valid;
        end
    end

    // With a zero quartic term the first path solves b*y + c = 0.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_inf  <= w_inf;
            r4_num1 <= w_lin ? {1'b0, w_mc} : w_n1a[NW-1:0];
            r4_den1 <= w_lin ? {1'b0, w_mb} : {w_ma, 1'b0};
            r4_v1   <= w_lin ? w_lin_v : w_v1q;
            r4_num2 <= w_n2a[NW-1:0];
            r4_den2 <= {w_ma, 1'b0};
            r4_v2   <= !w_lin && w_v2q;
        end
    end

    // Dividers: y scaled by 2^(2F).
    bqs_pkg::t_flow w_flow_q;
    logic           w_q1_valid, w_q2_valid;
    logic [QW-1:0]  w_q1, w_q2;
    logic [1:0]     w_sbq1;
    logic           w_sbq2;

    assign w_flow_q = '{valid: r4_valid, advance: w_adv};

    bqs_div #(
        .NUM_W      (NW),
        .DEN_W      (DNW),
        .FRAC_SHIFT (2 * F),
        .SB_W       (2)
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow_q),
        .i_num   (r4_num1),
        .i_den   (r4_den1),
        .i_sb    ({r4_inf, r4_v1}),
        .o_valid (w_q1_valid),
        .o_quo   (w_q1),
        .o_sb    (w_sbq1)
    );

    bqs_div #(
        .NUM_W      (NW),
        .DEN_W      (DNW),
        .FRAC_SHIFT (2 * F),
        .SB_W       (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow_q),
        .i_num   (r4_num2),
        .i_den   (r4_den2),
        .i_sb    (r4_v2),
        .o_valid (w_q2_valid),
        .o_quo   (w_q2),
        .o_sb    (w_sbq2)
    );

    // Square roots of the two y values.
    bqs_pkg::t_flow w_flow_r;
    logic           w_r1_valid, w_r2_valid;
    logic [RTW-1:0] w_rt1, w_rt2;
    logic [1:0]     w_sbr1;
    logic           w_sbr2;

    assign w_flow_r = '{valid: w_q1_valid, advance: w_adv};

    bqs_isqrt #(
        .IN_W (QW),
        .SB_W (2)
    ) u_root_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow_r),
        .i_rad   (w_q1),
        .i_sb    (w_sbq1),
        .o_valid (w_r1_valid),
        .o_root  (w_rt1),
        .o_sb    (w_sbr1)
    );

    bqs_isqrt #(
        .IN_W (QW),
        .SB_W (1)
    ) u_root_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow_r),
        .i_rad   (w_q2),
        .i_sb    (w_sbq2),
        .o_valid (w_r2_valid),
        .o_root  (w_rt2),
        .o_sb    (w_sbr2)
    );

    // Output stage: saturate, place the roots and count them.
    logic [W-1:0]     w_sat1, w_sat2, w_pos0, w_pos1;
    logic             w_v1, w_v2;
    logic [CNT_W-1:0] w_count;

    assign w_v1 = w_sbr1[0];
    assign w_v2 = w_sbr2;

    always_comb begin
        w_sat1 = (CW'(w_rt1) > CW'(MAXV)) ? MAXV : W'(w_rt1);
        w_sat2 = (CW'(w_rt2) > CW'(MAXV)) ? MAXV : W'(w_rt2);
        // When only the second y is valid its roots move to the front.
        w_pos0 = w_v1 ? w_sat1 : (w_v2 ? w_sat2 : '0);
        w_pos1 = (w_v1 && w_v2) ? w_sat2 : '0;
        unique case ({w_v1, w_v2})
            2'b11:   w_count = bqs_pkg::ROOTS_QUAD;
            2'b10:   w_count = bqs_pkg::ROOTS_PAIR;
            2'b01:   w_count = bqs_pkg::ROOTS_PAIR;
            default: w_count = bqs_pkg::ROOTS_NONE;
        endcase
    end

    logic             r_out_inf;
    logic [CNT_W-1:0] r_out_count;
    logic [W-1:0]     r_out_root0, r_out_root1, r_out_root2, r_out_root3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_inf   <= w_sbr1[1];
            r_out_count <= w_count;
            r_out_root0 <= w_pos0;
            r_out_root1 <= ~w_pos0 + {{(W-1){1'b0}}, 1'b1};
            r_out_root2 <= w_pos1;
            r_out_root3 <= ~w_pos1 + {{(W-1){1'b0}}, 1'b1};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_inf;
    assign m_axis_tdata  = OUT_TW'({r_out_root3, r_out_root2, r_out_root1, r_out_root0,
                                    r_out_count});

    // Checks on the solver's own logic.
    a_count_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count == bqs_pkg::ROOTS_NONE) ||
                        (r_out_count == bqs_pkg::ROOTS_PAIR) ||
                        (r_out_count == bqs_pkg::ROOTS_QUAD))
        else $error("root count holds an unused code");

    a_inf_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_inf) |-> (r_out_count == bqs_pkg::ROOTS_NONE))
        else $error("infinite solutions reported together with roots");

    a_pair_negated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_root0 + r_out_root1) == '0) &&
                        ((r_out_root2 + r_out_root3) == '0))
        else $error("root pair is not symmetric");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is stalled");

    a_paths_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q1_valid == w_q2_valid) && (w_r1_valid == w_r2_valid))
        else $error("the two root paths are out of step");

endmodule

### test/tb_biquadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquadratic_root_solver_top: self-checking bench of the biquadratic solver
// Drives coefficient items through the input stream, predicts every result
// item with exact wide integer arithmetic, and compares each output field in
// order while both stream sides idle at random, apart from the last phase.
// ----------------------------------------------------------------------------
module tb_biquadratic_root_solver_top;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int IN_TW     = 96;
    localparam int OUT_TW    = 136;
    localparam int LATENCY   = 136;
    localparam int IDLE_LIMIT = 4000;

    typedef logic [127:0] t_wide;

    typedef struct {
        logic                             infinite;
        logic [bqs_pkg::ROOT_COUNT_W-1:0] count;
        logic [DW-1:0]                    root [4];
    } t_roots;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_TW-1:0]   s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]  m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    t_roots expected_roots [$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     quiet_cycles = 0;

    biquadratic_root_solver_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Floor square root, one bit per step.
    function automatic t_wide isqrt(t_wide n);
        t_wide res;
        t_wide cand;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (t_wide'(1) << i);
            if (cand * cand <= n) res = cand;
        end
        return res;
    endfunction

    // Signed sum of two magnitude and sign pairs.
    function automatic void signed_sum(t_wide x, bit xn, t_wide y, bit yn,
                                       output t_wide r, output bit rn);
        if (xn == yn) begin
            r = x + y; rn = xn;
        end else if (x >= y) begin
            r = x - y; rn = xn;
        end else begin
            r = y - x; rn = yn;
        end
    endfunction

    // Root of y = num / den; false when y is negative.
    function automatic bit root_of_ratio(t_wide num, bit nn, t_wide den, bit dn,
                                         output logic [DW-1:0] r);
        t_wide q;
        t_wide x;
        if (num != 0 && nn != dn) return 1'b0;
        q = (num << (2 * FB)) / den;
        x = isqrt(q);
        r = (x > t_wide'(32'h7fff_ffff)) ? 32'h7fff_ffff : x[DW-1:0];
        return 1'b1;
    endfunction

    function automatic void split(logic [DW-1:0] v, output t_wide m, output bit n);
        logic [DW-1:0] t;
        n = v[DW-1];
        t = n ? (~v + 1'b1) : v;
        m = t_wide'(t);
    endfunction

    // Predicts the result item of one coefficient set.
    function automatic t_roots solve_biquad(logic [DW-1:0] a, logic [DW-1:0] b,
                                            logic [DW-1:0] c);
        t_roots res;
        t_wide ma, mb, mc, b2, p, d, s, n1, n2;
        bit na, nb, nc, n1n, n2n, ok;
        logic [DW-1:0] r;
        logic [DW-1:0] found [2];
        int k;
        k = 0;
        found[0] = '0;
        found[1] = '0;
        ok = 1'b1;
        d = '0;
        res.infinite = 1'b0;
        split(a, ma, na);
        split(b, mb, nb);
        split(c, mc, nc);
        if (ma == 0 && mb == 0 && mc == 0) begin
            res.infinite = 1'b1;
        end else if (ma == 0 && mb != 0) begin
            if (root_of_ratio(mc, !nc, mb, nb, r)) begin
                found[0] = r; k = 1;
            end
        end else if (ma != 0) begin
            b2 = mb * mb;
            p = (ma * mc) << 2;
            if (na != nc) d = b2 + p;
            else if (p > b2) ok = 1'b0;
            else d = b2 - p;
            if (ok) begin
                s = isqrt(d);
                signed_sum(mb, !nb, s, 1'b0, n1, n1n);
                signed_sum(mb, !nb, s, 1'b1, n2, n2n);
                if (root_of_ratio(n1, n1n, ma << 1, na, r)) begin
                    found[k] = r; k++;
                end
                if (s != 0 && root_of_ratio(n2, n2n, ma << 1, na, r)) begin
                    found[k] = r; k++;
                end
            end
        end
        res.count = (k == 2) ? bqs_pkg::ROOTS_QUAD :
                    (k == 1) ? bqs_pkg::ROOTS_PAIR : bqs_pkg::ROOTS_NONE;
        for (int i = 0; i < 2; i++) begin
            res.root[2*i]   = found[i];
            res.root[2*i+1] = -found[i];
        end
        return res;
    endfunction

    // Sends one coefficient item, with random idle cycles before it.
    task automatic send_coefs(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {c, b, a};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_roots.push_back(solve_biquad(a, b, c));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge i_clk);
    endtask

    // Result checking and receiver stalls.
    always @(posedge i_clk) begin
        t_roots e;
        logic [DW-1:0] got;
        if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_roots.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                e = expected_roots.pop_front();
                if (m_axis_tuser[0] !== e.infinite) begin
                    $error("infinite_solutions: expected %0d, actual %0d",
                           e.infinite, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata[2:0] !== e.count) begin
                    $error("root_count: expected %0d, actual %0d",
                           e.count, m_axis_tdata[2:0]);
                    mismatches++;
                end
                for (int i = 0; i < 4; i++) begin
                    got = m_axis_tdata[3 + DW*i +: DW];
                    if (got !== e.root[i]) begin
                        $error("root_%0d: expected %h, actual %h", i, e.root[i], got);
                        mismatches++;
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Field extremes and every special case.
    task automatic test_directed();
        send_coefs(0, 0, 0);                                   // all zero
        send_coefs(0, 0, 32'h0001_0000);                       // constant only
        send_coefs(0, 32'h0001_0000, 32'hfffc_0000);           // linear, valid
        send_coefs(0, 32'h0001_0000, 32'h0004_0000);           // linear, negative y
        send_coefs(0, 32'h8000_0000, 0);                       // linear, zero y
        send_coefs(0, 1, 32'h8000_0000);                       // linear, saturates
        send_coefs(32'h0001_0000, 0, 32'h0001_0000);           // negative discriminant
        send_coefs(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000); // double root
        send_coefs(32'h0001_0000, 32'hfffb_0000, 32'h0004_0000); // four roots
        send_coefs(32'h0001_0000, 32'hfffd_0000, 32'hfffc_0000); // one valid y
        send_coefs(32'hffff_0000, 32'h0003_0000, 32'h0004_0000); // y2 moves up
        send_coefs(32'h0001_0000, 32'hffff_0000, 0);           // zero root
        send_coefs(32'h7fff_ffff, 32'hffff_ffff, 0);           // tiny y
        send_coefs(1, 32'h8000_0001, 0);                       // huge y
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_coefs(1, 0, 32'h8000_0000);
    endtask

    // Random items: half equations built from known roots, the rest raw.
    task automatic test_random(int n);
        int ka, y1, y2, sel;
        logic [DW-1:0] a, b, c;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            if (sel < 5) begin
                ka = $urandom_range(1, 8) * ($urandom_range(1) ? 1 : -1);
                y1 = $urandom_range(80) - 20;
                y2 = $urandom_range(80) - 20;
                a = ka <<< FB;
                b = (-ka * (y1 + y2)) <<< FB;
                c = (ka * y1 * y2) <<< FB;
                a = a + ($urandom_range(3) == 0 ? $urandom_range(255) : 0);
            end else begin
                a = $urandom();
                b = $urandom();
                c = $urandom();
                if (sel == 5) a = 0;
                if (sel == 6) c = 0;
                if (sel == 7) a = $urandom_range(255) - 128;
            end
            send_coefs(a, b, c);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        recv_idle_pct = 76;
        test_directed();
        wait_drained();
        test_random(270);
        send_idle_pct = 76;
        recv_idle_pct = 20;
        test_random(280);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(280);
        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
src/bqs_pkg.sv
src/bqs_isqrt.sv
src/bqs_div.sv
src/biquadratic_root_solver_top.sv
test/tb_biquadratic_root_solver_top.sv
